// ===== rtl/ovn_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, register indexes and controller/datapath command types
// for the octave value noise block. No dependencies.
package ovn_pkg;

   localparam int MAX_WIDTH   = 128;
   localparam int MAX_HEIGHT  = 128;
   localparam int MAX_OCTAVES = 8;
   localparam int GRID_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(GRID_DEPTH);
   localparam int SEED_W      = 16;
   localparam int COORD_W     = 8;
   localparam int OCT_W       = 4;
   localparam int BIAS_W      = 16;
   localparam int WGT_W       = 32;
   localparam int DIV_W       = 48;
   localparam int STEP_W      = 6;
   localparam int MUL_A_W     = 17;
   localparam int CSR_IDX_W   = 4;
   localparam int REQ_DATA_W  = 48;

   localparam logic [STEP_W-1:0] STEPS_COORD  = STEP_W'(8);
   localparam logic [STEP_W-1:0] STEPS_BLEND  = STEP_W'(24);
   localparam logic [STEP_W-1:0] STEPS_WEIGHT = STEP_W'(40);
   localparam logic [STEP_W-1:0] STEPS_OUT    = STEP_W'(48);

   localparam logic [COORD_W-1:0] WIDTH_MAX  = COORD_W'(MAX_WIDTH);
   localparam logic [COORD_W-1:0] HEIGHT_MAX = COORD_W'(MAX_HEIGHT);
   localparam logic [OCT_W-1:0]   OCT_MAX    = OCT_W'(MAX_OCTAVES);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRID_WIDTH   = 4'd0,
      REG_GRID_HEIGHT  = 4'd1,
      REG_OCTAVE_COUNT = 4'd2,
      REG_SCALE_BIAS   = 4'd3
   } reg_idx_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_WRITE,
      OP_START,
      OP_DIV_MODX,
      OP_DIV_MODY,
      OP_DIV_RX,
      OP_DIV_RY,
      OP_DIV_Y2,
      OP_DIV_BX,
      OP_DIV_BY,
      OP_DIV_WT,
      OP_DIV_OUT,
      OP_ROW1,
      OP_ROW2,
      OP_READ,
      OP_MIX_A,
      OP_MIX_B,
      OP_MIX_C,
      OP_MIX_D,
      OP_MIX_E,
      OP_MIX_F,
      OP_MIX_G,
      OP_ACC,
      OP_NEXT,
      OP_ZERO,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        div_go;
      logic [1:0]  rd_sel;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic div_busy;
      logic oct_more;
      logic wsum_zero;
   } sts_type;

endpackage

// ===== rtl/ovn_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ovn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/ovn_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. The dividend arrives
// left-aligned; after the given step count the register holds the quotient.
// Depends on ovn_pkg.
module ovn_div
   import ovn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [WGT_W-1:0]  divisor,
   input  logic [STEP_W-1:0] steps,
   output logic              busy,
   output logic              done,
   output logic [DIV_W-1:0]  quotient,
   output logic [WGT_W-1:0]  remainder
);

   logic              busy_ff, done_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [DIV_W-1:0]  dvd_ff;
   logic [WGT_W-1:0]  rem_ff, dvs_ff;
   logic [WGT_W:0]    trial, diff;
   logic              fits;

   assign trial = {rem_ff, dvd_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= steps;
            dvd_ff  <= dividend;
            dvs_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[WGT_W-1:0] : trial[WGT_W-1:0];
            dvd_ff <= {dvd_ff[DIV_W-2:0], fits};
            cnt_ff <= cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/ovn_dp.sv =====
`timescale 1ns / 1ps
// Datapath: configuration registers, seed grid, divider, multiplier and
// accumulators. Driven by the controller's command. Depends on ovn_pkg,
// ovn_ram, ovn_div.
module ovn_dp
   import ovn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [REQ_DATA_W-1:0] req_data,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]           csr_data,
   output logic [SEED_W-1:0]     rsp_data
);

   logic [COORD_W-1:0] gw_ff, gh_ff, w_use, h_use, pitch;
   logic [OCT_W-1:0]   oc_ff, n_use, o_ff;
   logic [BIAS_W-1:0]  bias_ff, bias_use;

   logic [COORD_W-1:0] px_ff, py_ff, rx_ff, x1_ff, x2_ff, y1_ff, y2_ff;
   logic [SEED_W-1:0]  bx_ff, by_ff, top_ff, bot_ff, res_ff, out_ff;
   logic [SEED_W-1:0]  sa_ff, sb_ff, sc_ff, sd_ff, rd_data;
   logic [ADDR_W-1:0]  row1_ff, row2_ff, rd_addr;
   logic [WGT_W-1:0]   weight_ff, wsum_ff, nsum_ff;
   logic [DIV_W-1:0]   acc_ff;
   logic               rd_pend_ff;

   logic [DIV_W-1:0]   dvd, quo;
   logic [WGT_W-1:0]   dvs, rem;
   logic [STEP_W-1:0]  steps;
   logic               div_done, div_busy;

   logic [MUL_A_W-1:0] ma;
   logic [WGT_W-1:0]   mb;
   logic [MUL_A_W+WGT_W-1:0] prod;
   logic [COORD_W-1:0] x1_c;
   logic [COORD_W:0]   xt_c;
   logic [WGT_W:0]     wsum_c, nsum_c;

   assign w_use    = (gw_ff == '0) ? COORD_W'(1) : (gw_ff > WIDTH_MAX) ? WIDTH_MAX : gw_ff;
   assign h_use    = (gh_ff == '0) ? COORD_W'(1) : (gh_ff > HEIGHT_MAX) ? HEIGHT_MAX : gh_ff;
   assign n_use    = (oc_ff > OCT_MAX) ? OCT_MAX : oc_ff;
   assign bias_use = (bias_ff == '0) ? BIAS_W'(1) : bias_ff;
   assign pitch    = w_use >> o_ff;

   assign sts.div_done  = div_done;
   assign sts.div_busy  = div_busy;
   assign sts.oct_more  = (o_ff < n_use) && (pitch != '0);
   assign sts.wsum_zero = (wsum_ff == '0);

   // divider operand selection
   always_comb begin
      dvd   = {px_ff, 40'b0};
      dvs   = WGT_W'(w_use);
      steps = STEPS_COORD;
      case (cmd.op)
         OP_DIV_MODX: begin dvd = {px_ff, 40'b0}; dvs = WGT_W'(w_use); end
         OP_DIV_MODY: begin dvd = {py_ff, 40'b0}; dvs = WGT_W'(h_use); end
         OP_DIV_RX:   begin dvd = {px_ff, 40'b0}; dvs = WGT_W'(pitch); end
         OP_DIV_RY:   begin dvd = {py_ff, 40'b0}; dvs = WGT_W'(pitch); end
         OP_DIV_Y2: begin
            dvd = {y1_ff + pitch, 40'b0};
            dvs = WGT_W'(h_use);
         end
         OP_DIV_BX: begin
            dvd = {rx_ff, 40'b0}; dvs = WGT_W'(pitch); steps = STEPS_BLEND;
         end
         OP_DIV_BY: begin
            dvd = {y1_ff == py_ff ? COORD_W'(0) : py_ff - y1_ff, 40'b0};
            dvs = WGT_W'(pitch); steps = STEPS_BLEND;
         end
         OP_DIV_WT: begin
            dvd = {weight_ff, 16'b0}; dvs = WGT_W'(bias_use); steps = STEPS_WEIGHT;
         end
         OP_DIV_OUT: begin
            dvd = {nsum_ff, 16'b0}; dvs = wsum_ff; steps = STEPS_OUT;
         end
         default: ;
      endcase
   end

   ovn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (cmd.div_go),
      .dividend  (dvd),
      .divisor   (dvs),
      .steps     (steps),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   // multiplier operand selection
   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.op)
         OP_ROW1:  begin ma = MUL_A_W'(y1_ff); mb = WGT_W'(w_use); end
         OP_ROW2:  begin ma = MUL_A_W'(y2_ff); mb = WGT_W'(w_use); end
         OP_MIX_A: begin ma = 17'h10000 - MUL_A_W'(bx_ff); mb = WGT_W'(sa_ff); end
         OP_MIX_B: begin ma = MUL_A_W'(bx_ff); mb = WGT_W'(sb_ff); end
         OP_MIX_C: begin ma = 17'h10000 - MUL_A_W'(bx_ff); mb = WGT_W'(sc_ff); end
         OP_MIX_D: begin ma = MUL_A_W'(bx_ff); mb = WGT_W'(sd_ff); end
         OP_MIX_E: begin ma = 17'h10000 - MUL_A_W'(by_ff); mb = WGT_W'(top_ff); end
         OP_MIX_F: begin ma = MUL_A_W'(by_ff); mb = WGT_W'(bot_ff); end
         OP_MIX_G: begin ma = MUL_A_W'(acc_ff[31:16]); mb = weight_ff; end
         default: ;
      endcase
   end

   assign prod = ma * mb;

   always_comb begin
      case (cmd.rd_sel)
         2'd0:    rd_addr = row1_ff + ADDR_W'(x1_ff);
         2'd1:    rd_addr = row1_ff + ADDR_W'(x2_ff);
         2'd2:    rd_addr = row2_ff + ADDR_W'(x1_ff);
         default: rd_addr = row2_ff + ADDR_W'(x2_ff);
      endcase
   end

   // every 14-bit address lies inside the grid, so writes are never dropped
   ovn_ram #(.WIDTH(SEED_W), .DEPTH(GRID_DEPTH)) u_grid (
      .clock   (clock),
      .wr_en   (cmd.op == OP_WRITE),
      .wr_addr (req_data[ADDR_W-1:0]),
      .wr_data (req_data[29:14]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign x1_c   = px_ff - rem[COORD_W-1:0];
   assign xt_c   = {1'b0, x1_c} + {1'b0, pitch};
   assign wsum_c = {1'b0, wsum_ff} + {1'b0, weight_ff};
   assign nsum_c = {1'b0, nsum_ff} + {1'b0, acc_ff[47:16]};

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff      <= WIDTH_MAX;
         gh_ff      <= HEIGHT_MAX;
         oc_ff      <= OCT_W'(7);
         bias_ff    <= BIAS_W'(512);
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= (cmd.op == OP_READ);
         if (csr_valid) begin
            case (csr_index)
               REG_GRID_WIDTH:   gw_ff   <= csr_data[7:0];
               REG_GRID_HEIGHT:  gh_ff   <= csr_data[7:0];
               REG_OCTAVE_COUNT: oc_ff   <= csr_data[3:0];
               REG_SCALE_BIAS:   bias_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         sd_ff <= rd_data;
         sc_ff <= sd_ff;
         sb_ff <= sc_ff;
         sa_ff <= sb_ff;
      end
      case (cmd.op)
         OP_START: begin
            px_ff     <= {1'b0, req_data[36:30]};
            py_ff     <= {1'b0, req_data[43:37]};
            o_ff      <= '0;
            weight_ff <= 32'h0001_0000;
            wsum_ff   <= '0;
            nsum_ff   <= '0;
         end
         OP_DIV_MODX: if (div_done) px_ff <= rem[COORD_W-1:0];
         OP_DIV_MODY: if (div_done) py_ff <= rem[COORD_W-1:0];
         OP_DIV_RX: if (div_done) begin
            rx_ff <= rem[COORD_W-1:0];
            x1_ff <= x1_c;
            x2_ff <= (xt_c >= {1'b0, w_use}) ? COORD_W'(xt_c - {1'b0, w_use})
                                              : xt_c[COORD_W-1:0];
         end
         OP_DIV_RY: if (div_done) y1_ff <= py_ff - rem[COORD_W-1:0];
         OP_DIV_Y2: if (div_done) y2_ff <= rem[COORD_W-1:0];
         OP_DIV_BX: if (div_done) bx_ff <= quo[SEED_W-1:0];
         OP_DIV_BY: if (div_done) by_ff <= quo[SEED_W-1:0];
         OP_DIV_WT: if (div_done) begin
            weight_ff <= (quo[47:32] != '0) ? '1 : quo[31:0];
         end
         OP_DIV_OUT: if (div_done) begin
            res_ff <= (quo[47:16] != '0) ? '1 : quo[15:0];
         end
         OP_ROW1:  row1_ff <= prod[ADDR_W-1:0];
         OP_ROW2:  row2_ff <= prod[ADDR_W-1:0];
         OP_MIX_A: acc_ff <= prod[DIV_W-1:0];
         OP_MIX_B: acc_ff <= acc_ff + prod[DIV_W-1:0];
         OP_MIX_C: begin
            top_ff <= acc_ff[31:16];
            acc_ff <= prod[DIV_W-1:0];
         end
         OP_MIX_D: acc_ff <= acc_ff + prod[DIV_W-1:0];
         OP_MIX_E: begin
            bot_ff <= acc_ff[31:16];
            acc_ff <= prod[DIV_W-1:0];
         end
         OP_MIX_F: acc_ff <= acc_ff + prod[DIV_W-1:0];
         OP_MIX_G: begin
            acc_ff  <= prod[DIV_W-1:0];
            wsum_ff <= wsum_c[WGT_W] ? '1 : wsum_c[WGT_W-1:0];
         end
         OP_ACC:  nsum_ff <= nsum_c[WGT_W] ? '1 : nsum_c[WGT_W-1:0];
         OP_NEXT: o_ff <= o_ff + OCT_W'(1);
         OP_ZERO: res_ff <= '0;
         OP_EMIT: out_ff <= res_ff;
         default: ;
      endcase
   end

   assign rsp_data = out_ff;

endmodule

// ===== rtl/ovn_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences seed writes and the per-octave steps of a query,
// and holds the result valid flag. Depends on ovn_pkg.
module ovn_ctrl
   import ovn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_func,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_MODX, S_MODY, S_OCT, S_RX, S_RY, S_Y2, S_BX, S_BY,
      S_ROW1, S_ROW2, S_RD0, S_RD1, S_RD2, S_RD3, S_RDW,
      S_MA, S_MB, S_MC, S_MD, S_ME, S_MF, S_MG, S_ACC, S_WT, S_NEXT,
      S_FIN, S_OUT, S_EMIT
   } state_type;

   state_type state_ff;
   logic      wait_ff, rsp_valid_ff, rsp_free, is_div;

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign is_div   = (state_ff == S_MODX) || (state_ff == S_MODY) || (state_ff == S_RX) ||
                     (state_ff == S_RY) || (state_ff == S_Y2) || (state_ff == S_BX) ||
                     (state_ff == S_BY) || (state_ff == S_WT) || (state_ff == S_OUT);

   always_comb begin
      cmd.op     = OP_NOP;
      cmd.div_go = is_div && !wait_ff;
      cmd.rd_sel = 2'd0;
      case (state_ff)
         S_IDLE:  if (req_valid) cmd.op = req_func ? OP_START : OP_WRITE;
         S_MODX:  cmd.op = OP_DIV_MODX;
         S_MODY:  cmd.op = OP_DIV_MODY;
         S_RX:    cmd.op = OP_DIV_RX;
         S_RY:    cmd.op = OP_DIV_RY;
         S_Y2:    cmd.op = OP_DIV_Y2;
         S_BX:    cmd.op = OP_DIV_BX;
         S_BY:    cmd.op = OP_DIV_BY;
         S_ROW1:  cmd.op = OP_ROW1;
         S_ROW2:  cmd.op = OP_ROW2;
         S_RD0:   begin cmd.op = OP_READ; cmd.rd_sel = 2'd0; end
         S_RD1:   begin cmd.op = OP_READ; cmd.rd_sel = 2'd1; end
         S_RD2:   begin cmd.op = OP_READ; cmd.rd_sel = 2'd2; end
         S_RD3:   begin cmd.op = OP_READ; cmd.rd_sel = 2'd3; end
         S_MA:    cmd.op = OP_MIX_A;
         S_MB:    cmd.op = OP_MIX_B;
         S_MC:    cmd.op = OP_MIX_C;
         S_MD:    cmd.op = OP_MIX_D;
         S_ME:    cmd.op = OP_MIX_E;
         S_MF:    cmd.op = OP_MIX_F;
         S_MG:    cmd.op = OP_MIX_G;
         S_ACC:   cmd.op = OP_ACC;
         S_WT:    cmd.op = OP_DIV_WT;
         S_NEXT:  cmd.op = OP_NEXT;
         S_FIN:   if (sts.wsum_zero) cmd.op = OP_ZERO;
         S_OUT:   cmd.op = OP_DIV_OUT;
         S_EMIT:  if (rsp_free) cmd.op = OP_EMIT;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready && !(state_ff == S_EMIT && rsp_free)) rsp_valid_ff <= 1'b0;
         if (is_div) begin
            if (!wait_ff) begin
               wait_ff <= 1'b1;
            end else if (sts.div_done) begin
               wait_ff <= 1'b0;
               case (state_ff)
                  S_MODX:  state_ff <= S_MODY;
                  S_MODY:  state_ff <= S_OCT;
                  S_RX:    state_ff <= S_RY;
                  S_RY:    state_ff <= S_Y2;
                  S_Y2:    state_ff <= S_BX;
                  S_BX:    state_ff <= S_BY;
                  S_BY:    state_ff <= S_ROW1;
                  S_WT:    state_ff <= S_NEXT;
                  default: state_ff <= S_EMIT;
               endcase
            end
         end else begin
            case (state_ff)
               S_IDLE:  if (req_valid && req_func) state_ff <= S_MODX;
               S_OCT:   state_ff <= sts.oct_more ? S_RX : S_FIN;
               S_ROW1:  state_ff <= S_ROW2;
               S_ROW2:  state_ff <= S_RD0;
               S_RD0:   state_ff <= S_RD1;
               S_RD1:   state_ff <= S_RD2;
               S_RD2:   state_ff <= S_RD3;
               S_RD3:   state_ff <= S_RDW;
               S_RDW:   state_ff <= S_MA;
               S_MA:    state_ff <= S_MB;
               S_MB:    state_ff <= S_MC;
               S_MC:    state_ff <= S_MD;
               S_MD:    state_ff <= S_ME;
               S_ME:    state_ff <= S_MF;
               S_MF:    state_ff <= S_MG;
               S_MG:    state_ff <= S_ACC;
               S_ACC:   state_ff <= S_WT;
               S_NEXT:  state_ff <= S_OCT;
               S_FIN:   state_ff <= sts.wsum_zero ? S_EMIT : S_OUT;
               S_EMIT: if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/octave_value_noise_2d.sv =====
`timescale 1ns / 1ps
// Top level of the octave value noise block. Depends on ovn_pkg, ovn_ctrl,
// ovn_dp.
//
// A write item (tuser func 0) stores one Q0.16 seed. A query item (func 1)
// returns one Q0.16 noise value. Query time is set by the bit-serial
// divider: two coordinate wraps, then per octave the coordinate and blend
// divisions, the address, seed read and multiply steps and the weight
// division, then a normalizing division. One item is in work at a time; a
// finished result waits in the output register while the next item is
// accepted. The seed grid has no reset; read only written entries.
module octave_value_noise_2d
   import ovn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // seed_address[13:0], seed_value[29:14], pixel_x[36:30], pixel_y[43:37]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func[0]
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // noise_value[15:0]
   output logic [SEED_W-1:0]     rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]           csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   ovn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_func  (req_tuser[0]),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ovn_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_tdata)
   );

   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !sts.div_busy)
      else $error("divider busy while accepting items");

   a_query_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0]) |=> !req_tready)
      else $error("query did not start");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> (cmd.op == OP_DIV_MODX || cmd.op == OP_DIV_MODY ||
                        cmd.op == OP_DIV_RX || cmd.op == OP_DIV_RY ||
                        cmd.op == OP_DIV_Y2 || cmd.op == OP_DIV_BX ||
                        cmd.op == OP_DIV_BY || cmd.op == OP_DIV_WT ||
                        cmd.op == OP_DIV_OUT))
      else $error("division result with no consumer");

endmodule

// ===== dv/octave_value_noise_2d_tb.sv =====
`timescale 1ns / 1ps
// Testbench for octave_value_noise_2d: a local fixed-point noise predictor
// checks every query result. Seeds a query reads are written first.
// Depends on ovn_pkg and the octave_value_noise_2d RTL.
module octave_value_noise_2d_tb;
   import ovn_pkg::*;

   localparam int QUIET_LIMIT = 20000;
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [SEED_W-1:0]     rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [15:0]           csr_data = '0;

   // local copy of block state
   logic [15:0] seed_mem [GRID_DEPTH];
   bit          seed_set [GRID_DEPTH];
   logic [7:0]  cur_width = 8'd128;
   logic [7:0]  cur_height = 8'd128;
   logic [3:0]  cur_octaves = 4'd7;
   logic [15:0] cur_bias = 16'd512;

   logic [15:0] expected_noise [$];
   int unsigned seeds_touched [$];
   int  mismatches = 0;
   int  items_sent = 0;
   int  queries_sent = 0;
   int  results_seen = 0;
   int  quiet_cycles = 0;
   int  rsp_wait = 0;
   bit  rsp_took = 0;
   bit  busy_sides = 1;

   octave_value_noise_2d DUT (.*);

   always #10 clock = ~clock;

   function automatic longint unsigned seed_at(input longint unsigned idx);
      seeds_touched.push_back(int'(idx));
      return seed_mem[idx];
   endfunction

   function automatic longint unsigned lerp16(input longint unsigned a, b, t);
      return ((65536 - t) * a + t * b) >> 16;
   endfunction

   function automatic longint unsigned sat32(input longint unsigned v);
      return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
   endfunction

   function automatic logic [15:0] predict_noise(input logic [6:0] px_in, py_in);
      longint unsigned w, h, n, bias, wt, wsum, nsum, px, py, pitch;
      longint unsigned x1, y1, x2, y2, bx, by, top, bot, v, q;
      seeds_touched.delete();
      w = cur_width;
      h = cur_height;
      n = cur_octaves;
      bias = (cur_bias == 0) ? 1 : cur_bias;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      if (n > MAX_OCTAVES) n = MAX_OCTAVES;
      px = px_in % w;
      py = py_in % h;
      wt = 65536;
      wsum = 0;
      nsum = 0;
      for (int o = 0; o < n; o++) begin
         pitch = w >> o;
         if (pitch == 0) break;
         x1 = (px / pitch) * pitch;
         y1 = (py / pitch) * pitch;
         x2 = (x1 + pitch) % w;
         y2 = (y1 + pitch) % h;
         bx = ((px - x1) << 16) / pitch;
         by = ((py - y1) << 16) / pitch;
         top = lerp16(seed_at(y1 * w + x1), seed_at(y1 * w + x2), bx);
         bot = lerp16(seed_at(y2 * w + x1), seed_at(y2 * w + x2), bx);
         v = lerp16(top, bot, by);
         wsum = sat32(wsum + wt);
         nsum = sat32(nsum + sat32((v * wt) >> 16));
         wt = sat32((wt << 8) / bias);
      end
      if (wsum == 0) return 16'd0;
      q = (nsum << 16) / wsum;
      return (q > 65535) ? 16'hFFFF : q[15:0];
   endfunction

   task automatic send_item(input logic func, input logic [REQ_DATA_W-1:0] data);
      int gap;
      gap = busy_sides ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = func;
      req_tdata = data;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_seed(input logic [13:0] addr, input logic [15:0] val);
      send_item(FUNC_WRITE, {18'd0, val, addr});
      seed_mem[addr] = val;
      seed_set[addr] = 1;
   endtask

   task automatic query_pixel(input logic [6:0] px, py);
      logic [15:0] noise;
      int unsigned need [$];
      noise = predict_noise(px, py);
      need = seeds_touched;
      foreach (need[i])
         if (!seed_set[need[i]]) write_seed(need[i][13:0], 16'($urandom));
      noise = predict_noise(px, py);
      req_tvalid = 1'b0;
      req_tuser = FUNC_QUERY;
      req_tdata = {4'd0, py, px, 30'd0};
      if (busy_sides) repeat ($urandom_range(0, 3)) @(negedge clock);
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_noise.push_back(noise);
      items_sent++;
      queries_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (expected_noise.size() != 0) @(posedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_reg(input reg_idx_type idx, input logic [15:0] val);
      wait_drained();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_GRID_WIDTH:   cur_width = val[7:0];
         REG_GRID_HEIGHT:  cur_height = val[7:0];
         REG_OCTAVE_COUNT: cur_octaves = val[3:0];
         REG_SCALE_BIAS:   cur_bias = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_config(input logic [7:0] w, h, input logic [3:0] n,
                             input logic [15:0] b);
      write_reg(REG_GRID_WIDTH, {8'd0, w});
      write_reg(REG_GRID_HEIGHT, {8'd0, h});
      write_reg(REG_OCTAVE_COUNT, {12'd0, n});
      write_reg(REG_SCALE_BIAS, b);
   endtask

   task automatic test_seed_extremes();
      set_config(8'd4, 8'd4, 4'd3, 16'd256);
      for (int i = 0; i < 16; i++) write_seed(14'(i), 16'hFFFF);
      query_pixel(7'd127, 7'd127);
      query_pixel(7'd0, 7'd0);
      for (int i = 0; i < 16; i++) write_seed(14'(i), 16'h0000);
      query_pixel(7'd127, 7'd0);
      write_seed(14'h3FFF, 16'hFFFF);
      write_seed(14'h3FFF, 16'h0000);
   endtask

   task automatic test_config_extremes();
      set_config(8'd0, 8'd0, 4'd0, 16'd0);
      query_pixel(7'd5, 7'd9);
      set_config(8'd255, 8'd255, 4'd15, 16'hFFFF);
      query_pixel(7'd127, 7'd127);
      set_config(8'd1, 8'd1, 4'd1, 16'd1);
      query_pixel(7'd64, 7'd3);
      set_config(8'd128, 8'd128, 4'd8, 16'd512);
      query_pixel(7'd77, 7'd31);
      set_config(8'd128, 8'd1, 4'd8, 16'd1);
      query_pixel(7'd127, 7'd1);
      set_config(8'd3, 8'd200, 4'd8, 16'h0100);
      query_pixel(7'd2, 7'd127);
   endtask

   // queries go out one at a time, each waiting for its result
   task automatic test_drained_queries();
      set_config(8'd16, 8'd8, 4'd4, 16'd384);
      for (int i = 0; i < 4; i++) begin
         query_pixel(7'($urandom), 7'($urandom));
         wait_drained();
      end
   endtask

   task automatic test_random_traffic();
      logic [7:0]  w, h;
      logic [3:0]  n;
      logic [15:0] b;
      int phase = 0;
      while (items_sent < 1800) begin
         busy_sides = (phase % 3) != 2;
         w = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(1, 24));
         h = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(1, 24));
         n = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(1, 4));
         b = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(128, 1024));
         set_config(w, h, n, b);
         for (int i = 0; i < 60; i++) begin
            if ($urandom_range(0, 3) == 0)
               query_pixel(7'($urandom), 7'($urandom));
            else
               write_seed(14'($urandom), 16'($urandom));
         end
         phase++;
      end
   endtask

   always @(negedge clock) begin
      if (rsp_took) begin
         rsp_wait = busy_sides ? $urandom_range(0, 3) : 0;
         rsp_took = 0;
      end
      if (rsp_wait > 0) begin
         rsp_tready = 1'b0;
         rsp_wait--;
      end else begin
         rsp_tready = !reset;
      end
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         rsp_took = 1;
         results_seen++;
         if (expected_noise.size() == 0) begin
            $display("%0t: unexpected noise result %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            if (rsp_tdata !== expected_noise[0]) begin
               $display("%0t: noise_value expected %h actual %h", $time,
                        expected_noise[0], rsp_tdata);
               mismatches++;
            end
            void'(expected_noise.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: timeout waiting for a handshake", $time);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_seed_extremes();
      test_config_extremes();
      test_drained_queries();
      test_random_traffic();
      req_tvalid = 1'b0;
      while (expected_noise.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d items, %0d noise queries, %0d results checked",
               items_sent, queries_sent, results_seen);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ovn_pkg.sv
rtl/ovn_ram.sv
rtl/ovn_div.sv
rtl/ovn_dp.sv
rtl/ovn_ctrl.sv
rtl/octave_value_noise_2d.sv
dv/octave_value_noise_2d_tb.sv
